[hdl/fcba_pkg.sv]
// Shared types and codes of the chain allocator.
package fcba_pkg;

	// Entries in the link table
	localparam int unsigned TABLE_DEPTH = 256;

	localparam logic       CMD_ALLOC   = 1'b0;
	localparam logic       CMD_FREE    = 1'b1;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NO_SPACE = 2'd1;
	localparam logic [1:0] ST_INVALID  = 2'd2;

	typedef struct packed {
		logic       command;
		logic [8:0] block_count;
		logic [8:0] chain_head;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] first_block;
	} rsp_t;

	// Controller to datapath
	typedef struct packed {
		logic       load;
		logic       restart;
		logic       clr_wr;
		logic       scan;
		logic       link_mode;
		logic       end_wr;
		logic       walk_rd;
		logic       walk_wr;
		logic       set_st;
		logic [1:0] st_code;
		logic       push;
	} ctl_t;

	// Datapath to controller
	typedef struct packed {
		logic cmd_free;
		logic cnt_zero;
		logic clr_last;
		logic scan_done;
		logic fill_done;
		logic cur_ok;
		logic out_busy;
	} sts_t;

endpackage

[hdl/fcba_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module fcba_ram #(
	parameter int unsigned WIDTH = 9,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[hdl/fcba_ctrl.sv]
// Sequencer for clearing, allocate scans, free walks and result handoff.
module fcba_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  fcba_pkg::sts_t sts,
	output fcba_pkg::ctl_t ctl
);
	import fcba_pkg::*;

	localparam logic [3:0] S_CLEAR    = 4'd0;
	localparam logic [3:0] S_IDLE     = 4'd1;
	localparam logic [3:0] S_DISPATCH = 4'd2;
	localparam logic [3:0] S_COUNT    = 4'd3;
	localparam logic [3:0] S_LINK     = 4'd4;
	localparam logic [3:0] S_TAIL     = 4'd5;
	localparam logic [3:0] S_WALK_CHK = 4'd6;
	localparam logic [3:0] S_WALK_WR  = 4'd7;
	localparam logic [3:0] S_DONE     = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_d;

	always_comb begin
		state_d   = state_q;
		ctl       = '0;
		req_ready = 1'b0;
		case (state_q)
			S_CLEAR: begin
				ctl.clr_wr = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					ctl.load = 1'b1;
					state_d  = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				if (sts.cmd_free) begin
					state_d = S_WALK_CHK;
				end else if (sts.cnt_zero) begin
					ctl.set_st  = 1'b1;
					ctl.st_code = ST_INVALID;
					state_d     = S_DONE;
				end else begin
					state_d = S_COUNT;
				end
			end
			S_COUNT: begin
				ctl.scan = 1'b1;
				if (sts.scan_done) begin
					if (!sts.fill_done) begin
						ctl.set_st  = 1'b1;
						ctl.st_code = ST_NO_SPACE;
						state_d     = S_DONE;
					end else begin
						ctl.restart = 1'b1;
						state_d     = S_LINK;
					end
				end
			end
			S_LINK: begin
				ctl.scan      = 1'b1;
				ctl.link_mode = 1'b1;
				if (sts.scan_done) begin
					state_d = S_TAIL;
				end
			end
			S_TAIL: begin
				ctl.end_wr = 1'b1;
				state_d    = S_DONE;
			end
			S_WALK_CHK: begin
				if (sts.cur_ok) begin
					ctl.walk_rd = 1'b1;
					state_d     = S_WALK_WR;
				end else begin
					state_d = S_DONE;
				end
			end
			S_WALK_WR: begin
				ctl.walk_wr = 1'b1;
				state_d     = S_WALK_CHK;
			end
			S_DONE: begin
				if (!sts.out_busy) begin
					ctl.push = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// No beat is taken while the table is being cleared
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> !req_ready)
		else $error("request taken during clear");

	// A link pass only follows a count pass that found enough blocks
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COUNT && state_d == S_LINK) |-> sts.fill_done)
		else $error("link pass without enough free blocks");

endmodule

[hdl/fcba_dp.sv]
// Link table, scan and walk counters, item and result registers.
module fcba_dp (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic [8:0]     cfg_wdata,
	input  fcba_pkg::req_t req,
	input  fcba_pkg::ctl_t ctl,
	output fcba_pkg::sts_t sts,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output fcba_pkg::rsp_t rsp
);
	import fcba_pkg::*;

	localparam int unsigned IW   = $clog2(TABLE_DEPTH);
	localparam int unsigned CW   = $clog2(TABLE_DEPTH + 1);
	localparam int unsigned LW   = $clog2(TABLE_DEPTH + 2);
	localparam int unsigned CURW = (LW > 9) ? LW : 9;
	localparam logic [LW-1:0] LINK_END  = LW'(TABLE_DEPTH);
	localparam logic [LW-1:0] LINK_FREE = LW'(TABLE_DEPTH + 1);

	logic [8:0]      act_q;
	logic            cmd_q;
	logic [8:0]      cnt_q;
	logic [CW-1:0]   ptr_q;
	logic            vld_s1;
	logic [IW-1:0]   idx_s1;
	logic [8:0]      found_q;
	logic [IW-1:0]   prev_q;
	logic            have_prev_q;
	logic [IW-1:0]   head_q;
	logic [1:0]      st_q;
	logic [CURW-1:0] cur_q;
	logic [CW-1:0]   steps_q;
	logic            out_valid_q;
	rsp_t            out_q;

	logic [CW-1:0]   lim;
	logic            ptr_end;
	logic            fill_done;
	logic            issue;
	logic            hit;
	logic            link_wr;
	logic            we;
	logic [IW-1:0]   waddr;
	logic [LW-1:0]   wdata;
	logic [IW-1:0]   raddr;
	logic [LW-1:0]   rdata;

	assign lim = (32'(act_q) > TABLE_DEPTH) ? CW'(TABLE_DEPTH) : CW'(act_q);

	assign ptr_end   = ptr_q >= lim;
	assign fill_done = found_q >= cnt_q;
	assign issue     = ctl.scan && !ptr_end && !fill_done;
	assign hit       = ctl.scan && vld_s1 && (rdata == LINK_FREE) && !fill_done;
	assign link_wr   = hit && ctl.link_mode && have_prev_q;

	always_comb begin
		we    = 1'b0;
		waddr = prev_q;
		wdata = LINK_FREE;
		if (ctl.clr_wr) begin
			we    = 1'b1;
			waddr = ptr_q[IW-1:0];
		end else if (ctl.end_wr) begin
			we    = 1'b1;
			wdata = LINK_END;
		end else if (ctl.walk_wr) begin
			we    = 1'b1;
			waddr = cur_q[IW-1:0];
		end else if (link_wr) begin
			we    = 1'b1;
			wdata = LW'(idx_s1);
		end
	end

	assign raddr = ctl.walk_rd ? cur_q[IW-1:0] : ptr_q[IW-1:0];

	fcba_ram #(
		.WIDTH(LW),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 9'd256;
		end else if (cfg_we) begin
			act_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q       <= '0;
			vld_s1      <= 1'b0;
			found_q     <= '0;
			have_prev_q <= 1'b0;
			steps_q     <= '0;
		end else begin
			if (ctl.load || ctl.restart) begin
				ptr_q       <= '0;
				vld_s1      <= 1'b0;
				found_q     <= '0;
				have_prev_q <= 1'b0;
				steps_q     <= '0;
			end else begin
				if (ctl.clr_wr || issue) begin
					ptr_q <= ptr_q + 1'b1;
				end
				vld_s1 <= issue;
				if (hit) begin
					found_q <= found_q + 1'b1;
					if (ctl.link_mode) begin
						have_prev_q <= 1'b1;
					end
				end
				if (ctl.walk_wr) begin
					steps_q <= steps_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			idx_s1 <= ptr_q[IW-1:0];
		end
		if (ctl.load) begin
			cmd_q  <= req.command;
			cnt_q  <= req.block_count;
			cur_q  <= CURW'(req.chain_head);
			head_q <= '0;
			st_q   <= ST_OK;
		end else begin
			if (ctl.set_st) begin
				st_q <= ctl.st_code;
			end
			if (hit && ctl.link_mode) begin
				prev_q <= idx_s1;
				if (!have_prev_q) begin
					head_q <= idx_s1;
				end
			end
			if (ctl.walk_wr) begin
				cur_q <= CURW'(rdata);
			end
		end
	end

	// Output register: hold the result until the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.push) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			out_q.status      <= st_q;
			out_q.first_block <= 8'(head_q);
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	assign sts.cmd_free  = (cmd_q == CMD_FREE);
	assign sts.cnt_zero  = (cnt_q == 9'd0);
	assign sts.clr_last  = (ptr_q == CW'(TABLE_DEPTH - 1));
	assign sts.scan_done = !vld_s1 && (ptr_end || fill_done);
	assign sts.fill_done = fill_done;
	assign sts.cur_ok    = (32'(cur_q) < 32'(lim)) && (32'(steps_q) < TABLE_DEPTH);
	assign sts.out_busy  = out_valid_q && !rsp_ready;

	// A link write always lands behind the scan read pointer
	assert property (@(posedge clk) disable iff (!arst_n)
		(link_wr && issue) |-> (CW'(prev_q) < ptr_q))
		else $error("link write overtakes scan read");

	// The scan never takes more blocks than requested
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.scan |-> (found_q <= cnt_q))
		else $error("found count above request");

	// A pushed result is never dropped over a waiting one
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.push |-> !(out_valid_q && !rsp_ready))
		else $error("result pushed over pending beat");

endmodule

[hdl/fat_chain_block_allocator.sv]
// Top level of the file allocation table chain allocator.
// One request is handled at a time. After reset the table is cleared in a pass over all
// TABLE_DEPTH entries, during which no request is taken (configuration writes still land).
// An allocate makes up to two pipelined scans of the link memory, one entry per cycle over
// the active range: a count pass and a link pass, each ending early once enough free
// blocks are seen. A free walks the chain one link at a time, a dependent memory read and
// then a write per link. The link memory, with a single write port and a single read port,
// sets these steps. The result sits in an output register, so the next request is taken
// while the previous result waits.
module fat_chain_block_allocator (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic [8:0]     cfg_wdata,
	input  logic           req_valid,
	output logic           req_ready,
	input  fcba_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output fcba_pkg::rsp_t rsp
);
	import fcba_pkg::*;

	ctl_t ctl;
	sts_t sts;

	fcba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.sts      (sts),
		.ctl      (ctl)
	);

	fcba_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.req      (req),
		.ctl      (ctl),
		.sts      (sts),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

endmodule

[tb/sv/tb_fat_chain_block_allocator.sv]
// Self-checking testbench for the chain allocator: random and directed requests against a predictor.
`timescale 1ns / 1ps

module tb_fat_chain_block_allocator;
	import fcba_pkg::*;

	localparam int unsigned N_BLOCKS  = 256;
	localparam logic [8:0]  LINK_END  = 9'(N_BLOCKS);
	localparam logic [8:0]  LINK_FREE = 9'(N_BLOCKS + 1);

	class alloc_scoreboard;
		logic [8:0]  link_tab [N_BLOCKS];
		logic [8:0]  active_reg;
		rsp_t        expected_q [$];
		logic [7:0]  live_heads [$];
		int unsigned errors;

		function new();
			for (int i = 0; i < N_BLOCKS; i++)
				link_tab[i] = LINK_FREE;
			active_reg = 9'd256;
			errors     = 0;
		endfunction

		function void set_active(logic [8:0] v);
			active_reg = v;
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction

		function logic [7:0] take_live_head();
			int unsigned idx;
			logic [7:0]  h;
			idx = $urandom_range(live_heads.size() - 1);
			h   = live_heads[idx];
			live_heads.delete(idx);
			return h;
		endfunction

		// Update the table copy for one accepted request and queue its result.
		function void note_request(req_t r);
			rsp_t        res;
			int unsigned lim, found, i, prev, cur, steps;
			logic [8:0]  nxt;
			bit          have_prev;
			res.status      = ST_OK;
			res.first_block = '0;
			lim = (active_reg > N_BLOCKS) ? N_BLOCKS : active_reg;
			if (r.command == CMD_ALLOC) begin
				if (r.block_count == 0) begin
					res.status = ST_INVALID;
				end else begin
					found = 0;
					for (i = 0; i < lim && found < r.block_count; i++)
						if (link_tab[i] == LINK_FREE)
							found++;
					if (found < r.block_count) begin
						res.status = ST_NO_SPACE;
					end else begin
						found     = 0;
						prev      = 0;
						have_prev = 0;
						for (i = 0; i < lim && found < r.block_count; i++) begin
							if (link_tab[i] == LINK_FREE) begin
								if (have_prev)
									link_tab[prev] = 9'(i);
								else
									res.first_block = 8'(i);
								prev      = i;
								have_prev = 1;
								found++;
							end
						end
						link_tab[prev] = LINK_END;
						live_heads = {live_heads, res.first_block};
					end
				end
			end else begin
				cur = r.chain_head;
				for (steps = 0; steps < N_BLOCKS; steps++) begin
					if (cur >= lim)
						break;
					nxt           = link_tab[cur];
					link_tab[cur] = LINK_FREE;
					cur           = nxt;
				end
			end
			expected_q = {expected_q, res};
		endfunction

		function void check_response(rsp_t got);
			rsp_t want;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected response, expected none, actual status %0d first_block %0d",
					$time, got.status, got.first_block);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			if (got.status !== want.status) begin
				$display("%0t: status mismatch, expected %0d actual %0d",
					$time, want.status, got.status);
				errors++;
			end
			if (got.first_block !== want.first_block) begin
				$display("%0t: first_block mismatch, expected %0d actual %0d",
					$time, want.first_block, got.first_block);
				errors++;
			end
		endfunction
	endclass

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       cfg_we    = 1'b0;
	logic [8:0] cfg_wdata = '0;
	logic       req_valid = 1'b0;
	logic       req_ready;
	req_t       req       = '0;
	logic       rsp_valid;
	logic       rsp_ready = 1'b0;
	rsp_t       rsp;

	alloc_scoreboard sb;
	bit              calm      = 0;
	bit              stall_req = 0;

	fat_chain_block_allocator dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// Response side: random backpressure, plus a long hold-off on request.
	initial begin
		int unsigned stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (rsp_valid && rsp_ready)
				sb.check_response(rsp);
			if (stall_left > 0) begin
				stall_left--;
				rsp_ready <= 1'b0;
			end else if (stall_req) begin
				stall_req  = 0;
				stall_left = 1500;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= calm || ($urandom_range(99) >= 26);
			end
		end
	end

	task automatic send_item(logic cmd, logic [8:0] cnt, logic [8:0] head);
		req_t r;
		r.command     = cmd;
		r.block_count = cnt;
		r.chain_head  = head;
		if (!calm) begin
			while ($urandom_range(99) < 26) begin
				req_valid <= 1'b0;
				@(posedge clk);
			end
		end
		req_valid <= 1'b1;
		req       <= r;
		do @(posedge clk); while (!req_ready);
		sb.note_request(r);
	endtask

	task automatic send_random();
		int unsigned roll;
		logic [8:0]  cnt, head;
		roll = $urandom_range(99);
		cnt  = 9'($urandom_range(511));
		head = 9'($urandom_range(511));
		if (roll < 40 && sb.live_heads.size() != 0) begin
			send_item(CMD_FREE, cnt, {1'b0, sb.take_live_head()});
		end else if (roll < 52) begin
			// stale or out-of-range head
			send_item(CMD_FREE, cnt, head);
		end else begin
			roll = $urandom_range(99);
			if (roll < 3)
				cnt = '0;
			else if (roll < 75)
				cnt = 9'($urandom_range(8, 1));
			else if (roll < 95)
				cnt = 9'($urandom_range(48, 1));
			send_item(CMD_ALLOC, cnt, head);
		end
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic write_active(logic [8:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		sb.set_active(v);
	endtask

	initial begin
		int unsigned act_set  [9];
		int unsigned item_set [9];
		act_set  = '{256, 2, 100, 511, 17, 1, 300, 0, 64};
		item_set = '{150, 40, 120, 80, 60, 30, 80, 20, 70};
		sb = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_active(9'd256);

		send_item(CMD_ALLOC, 9'd0,   9'd511);  // zero count
		send_item(CMD_ALLOC, 9'd1,   9'd0);
		send_item(CMD_ALLOC, 9'd3,   9'd0);
		send_item(CMD_FREE,  9'd511, 9'd0);
		send_item(CMD_ALLOC, 9'd2,   9'd0);    // non-contiguous chain
		send_item(CMD_FREE,  9'd0,   9'd2);    // free from the middle of a chain
		send_item(CMD_FREE,  9'd0,   9'd1);    // walk stops on a free entry
		send_item(CMD_FREE,  9'd0,   9'd511);
		send_item(CMD_FREE,  9'd0,   9'd256);
		send_item(CMD_ALLOC, 9'd257, 9'd0);
		send_item(CMD_ALLOC, 9'd511, 9'd0);
		send_item(CMD_ALLOC, 9'd256, 9'd0);    // too few free blocks
		send_item(CMD_FREE,  9'd0,   9'd0);
		send_item(CMD_ALLOC, 9'd256, 9'd0);    // whole table
		send_item(CMD_ALLOC, 9'd1,   9'd0);
		send_item(CMD_FREE,  9'd0,   9'd255);
		send_item(CMD_ALLOC, 9'd1,   9'd0);
		send_item(CMD_FREE,  9'd0,   9'd0);    // full-length walk
		drain();

		write_active(9'd1);
		send_item(CMD_ALLOC, 9'd1, 9'd0);
		send_item(CMD_ALLOC, 9'd1, 9'd0);
		send_item(CMD_FREE,  9'd0, 9'd1);
		send_item(CMD_FREE,  9'd0, 9'd0);
		drain();

		write_active(9'd0);
		send_item(CMD_ALLOC, 9'd1, 9'd0);
		send_item(CMD_FREE,  9'd0, 9'd0);
		drain();

		write_active(9'd511);
		send_item(CMD_ALLOC, 9'd256, 9'd0);
		send_item(CMD_FREE,  9'd0,   9'd0);
		drain();

		for (int p = 0; p < 9; p++) begin
			write_active(9'(act_set[p]));
			calm = (act_set[p] == 511);
			if (p == 2)
				stall_req = 1;
			for (int n = 0; n < item_set[p]; n++)
				send_random();
			drain();
		end
		calm = 0;

		repeat (600) @(posedge clk);
		if (sb.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

[filelist.f]
hdl/fcba_pkg.sv
hdl/fcba_ram.sv
hdl/fcba_ctrl.sv
hdl/fcba_dp.sv
hdl/fat_chain_block_allocator.sv
tb/sv/tb_fat_chain_block_allocator.sv
